@@ design/tfd_pkg.sv @@
// Shared definitions for the tagged frame deframer.
// Holds the mode codes, the tag patterns, the command/status structs and byte helpers.
// No dependencies.
`default_nettype none

package tfd_pkg;

    localparam int WS_HOLD_DEF = 16;
    localparam int MAX_RESULTS = 20;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Parse modes
    localparam logic [1:0] MODE_HUNT    = 2'd0;
    localparam logic [1:0] MODE_OWN     = 2'd1;
    localparam logic [1:0] MODE_SKIP    = 2'd2;
    localparam logic [1:0] MODE_PAYLOAD = 2'd3;

    // Four-byte patterns, byte 0 in the low bits
    localparam logic [31:0] HDR_WANTED = 32'h2349_5052;
    localparam logic [31:0] HDR_OWN    = 32'h2356_4155;
    localparam logic [31:0] TAG_END    = 32'h444E_4523;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_BRACE = 8'h7B;

    typedef struct packed {
        logic capture;
        logic parse;
        logic adv_tag;
        logic start_release;
        logic tag_one;
        logic push;
        logic emit_held;
        logic ovf_read;
        logic ovf_load;
        logic flush_read;
        logic flush_emit;
        logic commit_load;
        logic commit_done;
        logic end_frame;
    } tfd_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       tag_match;
        logic       tag_final;
        logic       rel_pending;
        logic       byte_is_hash;
        logic       commit_ws;
        logic       pend_full;
        logic       pend_empty;
        logic       held_valid;
        logic       can_emit;
    } tfd_stat_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    // Next match progress for a pattern of four distinct bytes
    function automatic logic [2:0] pat_advance(input logic [31:0] pat,
                                               input logic [1:0]  prog,
                                               input logic [7:0]  b);
        if (b == pat[8*prog +: 8]) begin
            return {1'b0, prog} + 3'd1;
        end
        return (b == pat[7:0]) ? 3'd1 : 3'd0;
    endfunction

endpackage

`default_nettype wire

@@ design/tfd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the pending whitespace queue. No dependencies.
`default_nettype none

module tfd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/tfd_ctrl.sv @@
// Controller state machine of the deframer: sequences decode, tag release,
// commits, whitespace flushes and frame ends. Depends on tfd_pkg.
`default_nettype none

module tfd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tfd_pkg::tfd_stat_t stat,
    output tfd_pkg::tfd_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_NEXT     = 4'd2;
    localparam logic [3:0] S_OVF_EMIT = 4'd3;
    localparam logic [3:0] S_OVF_RD   = 4'd4;
    localparam logic [3:0] S_OVF_LD   = 4'd5;
    localparam logic [3:0] S_CM_EMIT  = 4'd6;
    localparam logic [3:0] S_FL_RD    = 4'd7;
    localparam logic [3:0] S_FL_EMIT  = 4'd8;
    localparam logic [3:0] S_CM_LD    = 4'd9;
    localparam logic [3:0] S_END      = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] after_commit;

    assign in_ready     = (state_reg == S_IDLE);
    assign after_commit = stat.rel_pending ? S_NEXT : S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.mode != tfd_pkg::MODE_PAYLOAD)
                begin
                    cmd.parse  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.tag_match && stat.tag_final)
                begin
                    state_next = S_END;
                end
                else if (stat.tag_match)
                begin
                    cmd.adv_tag = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.start_release = 1'b1;
                    state_next        = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (!stat.rel_pending && stat.byte_is_hash)
                begin
                    cmd.tag_one = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.commit_ws && !stat.pend_full)
                begin
                    cmd.push        = 1'b1;
                    cmd.commit_done = 1'b1;
                    state_next      = after_commit;
                end
                else if (stat.commit_ws)
                begin
                    state_next = S_OVF_EMIT;
                end
                else
                begin
                    state_next = S_CM_EMIT;
                end
            end
            S_OVF_EMIT:
            begin
                if (!stat.held_valid || stat.can_emit)
                begin
                    cmd.emit_held = 1'b1;
                    state_next    = S_OVF_RD;
                end
            end
            S_OVF_RD:
            begin
                cmd.ovf_read = 1'b1;
                state_next   = S_OVF_LD;
            end
            S_OVF_LD:
            begin
                cmd.ovf_load    = 1'b1;
                cmd.commit_done = 1'b1;
                state_next      = after_commit;
            end
            S_CM_EMIT:
            begin
                if (!stat.held_valid || stat.can_emit)
                begin
                    cmd.emit_held = 1'b1;
                    state_next    = S_FL_RD;
                end
            end
            S_FL_RD:
            begin
                if (stat.pend_empty)
                begin
                    state_next = S_CM_LD;
                end
                else
                begin
                    cmd.flush_read = 1'b1;
                    state_next     = S_FL_EMIT;
                end
            end
            S_FL_EMIT:
            begin
                if (stat.can_emit)
                begin
                    cmd.flush_emit = 1'b1;
                    state_next     = S_FL_RD;
                end
            end
            S_CM_LD:
            begin
                cmd.commit_load = 1'b1;
                cmd.commit_done = 1'b1;
                state_next      = after_commit;
            end
            S_END:
            begin
                if (!stat.held_valid || stat.can_emit)
                begin
                    cmd.emit_held = 1'b1;
                    cmd.end_frame = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ design/tfd_datapath.sv @@
// Datapath of the deframer: header and tag matchers, held byte, whitespace queue
// (tfd_ram), result limit and output register. Depends on tfd_pkg and tfd_ram.
`default_nettype none

module tfd_datapath #(
    parameter int WS_HOLD = tfd_pkg::WS_HOLD_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        in_byte,
    input  wire tfd_pkg::tfd_cmd_t cmd,
    output tfd_pkg::tfd_stat_t     stat,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    localparam int PW = (WS_HOLD > 1) ? $clog2(WS_HOLD) : 1;
    localparam int CW = $clog2(WS_HOLD + 1);

    logic [1:0]    mode_reg;
    logic [1:0]    wprog_reg;
    logic [1:0]    oprog_reg;
    logic [1:0]    etp_reg;
    logic [1:0]    rel_n_reg;
    logic [1:0]    rel_idx_reg;
    logic          held_valid_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] head_reg;
    logic [PW-1:0] tail_reg;
    logic [tfd_pkg::RES_CNT_W-1:0] res_cnt_reg;
    logic          out_valid_reg;

    logic [7:0]    byte_reg;
    logic [7:0]    held_byte_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic [2:0]    w_adv;
    logic [2:0]    o_adv;
    logic [2:0]    e_adv;
    logic [7:0]    commit_char;
    logic          cap_ok;
    logic          load_req;
    logic          load_out;
    logic [7:0]    load_byte;
    logic [7:0]    rd_data;
    logic          ram_we;
    logic          ram_rd;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] tail_inc;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(WS_HOLD - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_adv = tfd_pkg::pat_advance(tfd_pkg::HDR_WANTED, wprog_reg, byte_reg);
    assign o_adv = tfd_pkg::pat_advance(tfd_pkg::HDR_OWN, oprog_reg, byte_reg);
    assign e_adv = tfd_pkg::pat_advance(tfd_pkg::TAG_END, etp_reg, byte_reg);

    assign commit_char = (rel_idx_reg < rel_n_reg) ? tfd_pkg::TAG_END[8*rel_idx_reg +: 8]
                                                   : byte_reg;

    assign head_inc = ptr_inc(head_reg);
    assign tail_inc = ptr_inc(tail_reg);

    // Results beyond the per-item limit are dropped
    assign cap_ok    = (res_cnt_reg < tfd_pkg::RES_CNT_W'(tfd_pkg::MAX_RESULTS));
    assign load_req  = (cmd.emit_held && held_valid_reg) || cmd.flush_emit;
    assign load_out  = load_req && cap_ok;
    assign load_byte = cmd.flush_emit ? rd_data : held_byte_reg;

    assign ram_we = cmd.push || cmd.ovf_load;
    assign ram_rd = cmd.ovf_read || cmd.flush_read;

    tfd_ram #(
        .WIDTH (8),
        .DEPTH (WS_HOLD),
        .ADDR_W(PW)
    ) u_ws_ram (
        .clk    (clk),
        .we     (ram_we),
        .wr_addr(tail_reg),
        .wr_data(commit_char),
        .rd_en  (ram_rd),
        .rd_addr(head_reg),
        .rd_data(rd_data)
    );

    always_comb
    begin
        stat.mode         = mode_reg;
        stat.tag_match    = (byte_reg == tfd_pkg::TAG_END[8*etp_reg +: 8]);
        stat.tag_final    = (etp_reg == 2'd3);
        stat.rel_pending  = (rel_idx_reg < rel_n_reg);
        stat.byte_is_hash = (byte_reg == tfd_pkg::CHAR_HASH);
        stat.commit_ws    = tfd_pkg::is_ws(commit_char);
        stat.pend_full    = (count_reg == CW'(WS_HOLD));
        stat.pend_empty   = (count_reg == '0);
        stat.held_valid   = held_valid_reg;
        stat.can_emit     = !out_valid_reg || out_ready || !cap_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= tfd_pkg::MODE_HUNT;
            wprog_reg      <= '0;
            oprog_reg      <= '0;
            etp_reg        <= '0;
            rel_n_reg      <= '0;
            rel_idx_reg    <= '0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            res_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                res_cnt_reg <= '0;
            end
            else if (load_out)
            begin
                res_cnt_reg <= res_cnt_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.parse)
            begin
                unique case (mode_reg)
                    tfd_pkg::MODE_HUNT:
                    begin
                        if (o_adv == 3'd4)
                        begin
                            mode_reg  <= tfd_pkg::MODE_OWN;
                            wprog_reg <= '0;
                            oprog_reg <= '0;
                            etp_reg   <= 2'd1;
                        end
                        else if (w_adv == 3'd4)
                        begin
                            mode_reg  <= tfd_pkg::MODE_SKIP;
                            wprog_reg <= '0;
                            oprog_reg <= '0;
                            etp_reg   <= '0;
                        end
                        else
                        begin
                            wprog_reg <= w_adv[1:0];
                            oprog_reg <= o_adv[1:0];
                        end
                    end
                    tfd_pkg::MODE_OWN:
                    begin
                        if (e_adv == 3'd4)
                        begin
                            mode_reg  <= tfd_pkg::MODE_HUNT;
                            wprog_reg <= '0;
                            oprog_reg <= '0;
                            etp_reg   <= '0;
                        end
                        else
                        begin
                            etp_reg <= e_adv[1:0];
                        end
                    end
                    tfd_pkg::MODE_SKIP:
                    begin
                        // Open the payload with '{' as the held byte
                        if (byte_reg == tfd_pkg::CHAR_BRACE)
                        begin
                            mode_reg       <= tfd_pkg::MODE_PAYLOAD;
                            etp_reg        <= '0;
                            held_valid_reg <= 1'b1;
                            count_reg      <= '0;
                            tail_reg       <= head_reg;
                        end
                    end
                    default:
                    begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end

            if (cmd.adv_tag)
            begin
                etp_reg <= etp_reg + 1'b1;
            end

            if (cmd.start_release)
            begin
                rel_n_reg   <= etp_reg;
                rel_idx_reg <= '0;
                etp_reg     <= '0;
            end

            if (cmd.tag_one)
            begin
                etp_reg <= 2'd1;
            end

            if (cmd.push)
            begin
                tail_reg  <= tail_inc;
                count_reg <= count_reg + 1'b1;
            end

            // Oldest whitespace becomes the held byte, new one queued behind
            if (cmd.ovf_load)
            begin
                head_reg       <= head_inc;
                tail_reg       <= tail_inc;
                held_valid_reg <= 1'b1;
            end

            if (cmd.flush_emit)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.commit_load)
            begin
                held_valid_reg <= 1'b1;
            end

            if (cmd.commit_done && (rel_idx_reg < rel_n_reg))
            begin
                rel_idx_reg <= rel_idx_reg + 1'b1;
            end

            if (cmd.end_frame)
            begin
                held_valid_reg <= 1'b0;
                count_reg      <= '0;
                tail_reg       <= head_reg;
                mode_reg       <= tfd_pkg::MODE_HUNT;
                wprog_reg      <= '0;
                oprog_reg      <= '0;
                etp_reg        <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= in_byte;
        end
        if (cmd.parse && (mode_reg == tfd_pkg::MODE_SKIP))
        begin
            held_byte_reg <= byte_reg;
        end
        else if (cmd.ovf_load)
        begin
            held_byte_reg <= rd_data;
        end
        else if (cmd.commit_load)
        begin
            held_byte_reg <= commit_char;
        end
        if (load_out)
        begin
            out_byte_reg <= load_byte;
            out_last_reg <= cmd.end_frame;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

@@ design/tagged_frame_deframer_top.sv @@
// Top level of the tagged frame deframer: streaming ports around the controller
// and datapath. Depends on tfd_pkg, tfd_ctrl, tfd_datapath (and tfd_ram below it).
`default_nettype none

// Takes one received byte per item and extracts the payload of wanted frames,
// from the '{' up to but not including the end tag, with trailing whitespace
// trimmed and the final kept byte marked by tlast; own frames are dropped whole.
// One item is worked at a time by the controller. A byte that yields no result
// (header hunt, skip, own frame, end tag progress) is only decoded, and the byte
// that completes an end tag also emits the held byte with tlast. A committed
// payload byte that is whitespace is queued; whitespace that overflows the queue
// emits the held byte and makes the oldest queued whitespace the held byte; any
// other byte emits the held byte, flushes the queued whitespace and becomes the
// held byte. A failed end tag repeats the commit for each released tag byte.
// The queue RAM has registered read data, and a stalled output adds its stall.
// Up to WS_HOLD trailing whitespace bytes are held back; the queue needs no
// clearing after reset.
module tagged_frame_deframer_top #(
    parameter int WS_HOLD = tfd_pkg::WS_HOLD_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] payload_byte
    output logic            m_axis_tlast    // frame_last
);

    tfd_pkg::tfd_cmd_t  cmd;
    tfd_pkg::tfd_stat_t stat;

    tfd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tfd_datapath #(
        .WS_HOLD(WS_HOLD)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (s_axis_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_byte (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for tagged_frame_deframer_top: feeds received bytes and
// checks every payload item against an in-bench prediction of the frame parser.
// Depends on tfd_pkg and the deframer RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int HOLD_DEPTH   = tfd_pkg::WS_HOLD_DEF;
    localparam int RANDOM_BYTES = 190;
    localparam int TAIL_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 200;

    // Header and tag patterns, first byte at index 0
    localparam logic [0:3][7:0] WANTED_HDR = {8'h52, 8'h50, 8'h49, 8'h23};
    localparam logic [0:3][7:0] OWN_HDR    = {8'h55, 8'h41, 8'h56, 8'h23};
    localparam logic [0:3][7:0] END_TAG    = {8'h23, 8'h45, 8'h4E, 8'h44};
    localparam logic [7:0]      OPEN_BRACE = 8'h7B;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_last;
    } payload_item_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    // Parser state mirrored by the predictor
    logic [1:0]    parse_mode;
    logic [1:0]    wanted_prog;
    logic [1:0]    own_prog;
    logic [2:0]    tag_prog;
    logic [7:0]    held_byte;
    logic          held_valid;
    logic [7:0]    blank_run[$];
    int            step_results;

    logic [7:0]    rx_queue[$];
    payload_item_t expected_payload[$];
    payload_item_t oldest_payload;

    int rx_gap;
    int out_stall;
    int err_count;
    int bytes_sent;
    int results_checked;
    int frames_closed;
    int directed_count;

    tagged_frame_deframer_top #(
        .WS_HOLD(HOLD_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic is_blank(input logic [7:0] b);
        case (b)
            8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] match_next(input logic [0:3][7:0] pat,
                                              input logic [1:0] prog,
                                              input logic [7:0] b);
        if (b == pat[prog])
        begin
            return {1'b0, prog} + 3'd1;
        end
        else if (b == pat[0])
        begin
            return 3'd1;
        end
        return 3'd0;
    endfunction

    function automatic void expect_payload(input logic [7:0] b, input logic last);
        if (step_results < tfd_pkg::MAX_RESULTS)
        begin
            expected_payload.push_back({b, last});
            step_results++;
        end
    endfunction

    function automatic void restart_hunt();
        parse_mode  = tfd_pkg::MODE_HUNT;
        wanted_prog = 2'd0;
        own_prog    = 2'd0;
        tag_prog    = 3'd0;
    endfunction

    // Keep one payload byte: whitespace waits in the run, anything else flushes it.
    function automatic void keep_byte(input logic [7:0] b);
        if (is_blank(b))
        begin
            if (blank_run.size() < HOLD_DEPTH)
            begin
                blank_run.push_back(b);
            end
            else
            begin
                // overflow: the oldest blank becomes the held byte
                if (held_valid)
                begin
                    expect_payload(held_byte, 1'b0);
                end
                held_byte  = blank_run.pop_front();
                held_valid = 1'b1;
                blank_run.push_back(b);
            end
        end
        else
        begin
            if (held_valid)
            begin
                expect_payload(held_byte, 1'b0);
            end
            foreach (blank_run[i])
            begin
                expect_payload(blank_run[i], 1'b0);
            end
            blank_run.delete();
            held_byte  = b;
            held_valid = 1'b1;
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [2:0] w;
        logic [2:0] o;
        logic [2:0] e;
        step_results = 0;
        case (parse_mode)
            tfd_pkg::MODE_HUNT:
            begin
                w = match_next(WANTED_HDR, wanted_prog, b);
                o = match_next(OWN_HDR, own_prog, b);
                if (o == 3'd4)
                begin
                    restart_hunt();
                    parse_mode = tfd_pkg::MODE_OWN;
                    tag_prog   = 3'd1;
                end
                else if (w == 3'd4)
                begin
                    restart_hunt();
                    parse_mode = tfd_pkg::MODE_SKIP;
                end
                else
                begin
                    wanted_prog = w[1:0];
                    own_prog    = o[1:0];
                end
            end
            tfd_pkg::MODE_OWN:
            begin
                e = match_next(END_TAG, tag_prog[1:0], b);
                if (e == 3'd4)
                begin
                    restart_hunt();
                end
                else
                begin
                    tag_prog = e;
                end
            end
            tfd_pkg::MODE_SKIP:
            begin
                if (b == OPEN_BRACE)
                begin
                    parse_mode = tfd_pkg::MODE_PAYLOAD;
                    tag_prog   = 3'd0;
                    held_valid = 1'b0;
                    blank_run.delete();
                    keep_byte(b);
                end
            end
            default:
            begin
                if (b == END_TAG[tag_prog[1:0]])
                begin
                    tag_prog = tag_prog + 3'd1;
                    if (tag_prog == 3'd4)
                    begin
                        if (held_valid)
                        begin
                            expect_payload(held_byte, 1'b1);
                        end
                        held_valid = 1'b0;
                        blank_run.delete();
                        restart_hunt();
                    end
                end
                else
                begin
                    // release the partial tag, then look at this byte afresh
                    for (int i = 0; i < tag_prog; i++)
                    begin
                        keep_byte(END_TAG[i]);
                    end
                    if (b == END_TAG[0])
                    begin
                        tag_prog = 3'd1;
                    end
                    else
                    begin
                        tag_prog = 3'd0;
                        keep_byte(b);
                    end
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    function automatic logic [7:0] pick_body_byte();
        case ($urandom_range(0, 9))
            0, 1:    return pick_blank();
            2:       return END_TAG[$urandom_range(0, 3)];
            3:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    task automatic queue_pattern(input logic [0:3][7:0] pat);
        for (int i = 0; i < 4; i++)
        begin
            rx_queue.push_back(pat[i]);
        end
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            rx_queue.push_back(s[i]);
        end
    endtask

    task automatic queue_random_frame();
        int         kind;
        int         n;
        int         r;
        logic [7:0] b;
        kind = $urandom_range(0, 19);
        if (kind < 3)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                rx_queue.push_back(pick_body_byte());
            end
        end
        else if (kind < 6)
        begin
            queue_pattern(OWN_HDR);
            if ($urandom_range(0, 2) == 0)
            begin
                // header '#' doubles as the start of the end tag
                queue_text("END");
            end
            else
            begin
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                begin
                    rx_queue.push_back(pick_body_byte());
                end
                queue_pattern(END_TAG);
            end
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                begin
                    rx_queue.push_back(WANTED_HDR[i]);
                end
            end
            queue_pattern(WANTED_HDR);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                b = pick_body_byte();
                if (b != OPEN_BRACE)
                begin
                    rx_queue.push_back(b);
                end
            end
            rx_queue.push_back(OPEN_BRACE);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
            begin
                rx_queue.push_back(pick_body_byte());
            end
            r = $urandom_range(0, 7);
            n = (r == 0) ? $urandom_range(HOLD_DEPTH - 1, HOLD_DEPTH + 4) :
                (r == 1) ? 0 : $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                rx_queue.push_back(pick_blank());
            end
            // leave a few frames open so the next bytes land in the payload
            if (kind != 19)
            begin
                queue_pattern(END_TAG);
            end
        end
    endtask

    // Input driver: predict on every accepted item, then present the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            rx_gap = 0;
            restart_hunt();
            held_byte  = 8'h00;
            held_valid = 1'b0;
            blank_run.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                deframe_byte(s_axis_tdata);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (rx_gap > 0)
                begin
                    rx_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (rx_queue.size() > 0)
                begin
                    s_axis_tdata  <= rx_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (rx_queue.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0)
                    begin
                        rx_gap = $urandom_range(1, 7);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each accepted item against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_payload.size() == 0)
                begin
                    $error("unexpected item: payload_byte 0x%02h frame_last %0d",
                           m_axis_tdata, m_axis_tlast);
                    err_count++;
                end
                else
                begin
                    oldest_payload = expected_payload.pop_front();
                    if (m_axis_tdata !== oldest_payload.payload_byte)
                    begin
                        $error("payload_byte mismatch: expected 0x%02h, got 0x%02h",
                               oldest_payload.payload_byte, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== oldest_payload.frame_last)
                    begin
                        $error("frame_last mismatch: expected %0d, got %0d",
                               oldest_payload.frame_last, m_axis_tlast);
                        err_count++;
                    end
                    results_checked++;
                    if (oldest_payload.frame_last)
                    begin
                        frames_closed++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_queue.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0)
            begin
                out_stall = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        // directed: byte extremes, own frame sharing its '#', tag before the brace,
        // a failed end tag and a trimmed trailing blank
        rx_queue.push_back(8'h00);
        rx_queue.push_back(8'hFF);
        queue_pattern(OWN_HDR);
        queue_text("END");
        queue_pattern(WANTED_HDR);
        queue_pattern(END_TAG);
        rx_queue.push_back(OPEN_BRACE);
        queue_text("a#Ex ");
        queue_pattern(END_TAG);
        directed_count = rx_queue.size();
        while (rx_queue.size() < directed_count + RANDOM_BYTES)
        begin
            queue_random_frame();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_queue.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_payload.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d received bytes (%0d directed), checked %0d payload items",
                 bytes_sent, directed_count, results_checked);
        $display("Closed %0d wanted frames, whitespace hold depth %0d, %0d errors",
                 frames_closed, HOLD_DEPTH, err_count);
        if (err_count == 0)
        begin
            $display("tagged_frame_deframer_top verification clean");
        end
        else
        begin
            $display("tagged_frame_deframer_top verification failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tagged_frame_deframer_top verification failed");
        $finish;
    end

endmodule
